/* design/assert_macros.svh */
// Assertion macros shared by the I2C EEPROM master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* design/i2cee_pkg.sv */
// Types and constants for the I2C EEPROM byte access master.
`default_nettype none
package i2cee_pkg;

	// Configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_SELECT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT   = 8'd1;
	localparam logic [6:0] DEVICE_SELECT_RST = 7'd80;
	localparam logic [7:0] ACK_TIMEOUT_RST   = 8'd200;

	// Bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_ST1    = 5'd1,
		PH_ST2    = 5'd2,
		PH_ST3    = 5'd3,
		PH_ST4    = 5'd4,
		PH_BSET   = 5'd5,
		PH_BHIGH  = 5'd6,
		PH_BLOW   = 5'd7,
		PH_AREL   = 5'd8,
		PH_APOLL  = 5'd9,
		PH_AEND   = 5'd10,
		PH_RREL   = 5'd11,
		PH_RHIGH1 = 5'd12,
		PH_RHIGH2 = 5'd13,
		PH_RLOW   = 5'd14,
		PH_SP1    = 5'd15,
		PH_SP2    = 5'd16,
		PH_SP3    = 5'd17
	} phase_t;

	// Live configuration
	typedef struct packed {
		logic [6:0] device_select;
		logic [7:0] ack_timeout;
	} cfg_t;

	// One tick's result beat
	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} res_t;

	// Outcome of launching the next step of a transaction
	typedef struct packed {
		phase_t     phase;
		logic       load;
		logic [7:0] byte_v;
	} launch_t;

endpackage
`default_nettype wire

/* design/i2cee_seq.sv */
// Tick-level I2C bus sequencer: start, byte send, acknowledge poll, byte read, stop.
`default_nettype none
`include "assert_macros.svh"
module i2cee_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire logic             start_req,
	input  wire logic             action,
	input  wire logic [7:0]       mem_address,
	input  wire logic [7:0]       write_data,
	input  wire logic             sda_in,
	input  wire i2cee_pkg::cfg_t  cfg,
	output i2cee_pkg::res_t       res
);

	// Pick the phase and byte for a transaction step
	function automatic i2cee_pkg::launch_t launch(input logic op_read, input logic [2:0] step,
			input logic [7:0] dev, input logic [7:0] addr, input logic [7:0] data);
		i2cee_pkg::launch_t l;
		l.phase = i2cee_pkg::PH_IDLE;
		l.load = 1'b0;
		l.byte_v = 8'd0;
		if (op_read) begin
			case (step)
				3'd0: l.phase = i2cee_pkg::PH_ST1;
				3'd1: begin l.phase = i2cee_pkg::PH_BSET; l.load = 1'b1; l.byte_v = dev; end
				3'd2: begin l.phase = i2cee_pkg::PH_BSET; l.load = 1'b1; l.byte_v = addr; end
				3'd3: l.phase = i2cee_pkg::PH_ST1;
				3'd4: begin
					l.phase = i2cee_pkg::PH_BSET;
					l.load = 1'b1;
					l.byte_v = {dev[7:1], 1'b1};
				end
				3'd5: l.phase = i2cee_pkg::PH_RREL;
				3'd6: l.phase = i2cee_pkg::PH_SP1;
				default: l.phase = i2cee_pkg::PH_IDLE;
			endcase
		end else begin
			case (step)
				3'd0: l.phase = i2cee_pkg::PH_ST1;
				3'd1: begin l.phase = i2cee_pkg::PH_BSET; l.load = 1'b1; l.byte_v = dev; end
				3'd2: begin l.phase = i2cee_pkg::PH_BSET; l.load = 1'b1; l.byte_v = addr; end
				3'd3: begin l.phase = i2cee_pkg::PH_BSET; l.load = 1'b1; l.byte_v = data; end
				3'd4: l.phase = i2cee_pkg::PH_SP1;
				default: l.phase = i2cee_pkg::PH_IDLE;
			endcase
		end
		return l;
	endfunction

	i2cee_pkg::phase_t phase_q, n_phase, cur;
	logic [3:0] bit_count_q, n_bit_count, bc_inc;
	logic [7:0] shift_q, n_shift;
	logic [7:0] ack_cnt_q, n_ack_cnt;
	logic [2:0] step_q, n_step, step_base, step_inc;
	logic       read_q, n_read;
	logic [7:0] addr_q, n_addr, data_q, n_data, rx_q, n_rx;
	logic       err_q, n_err, scl_q, n_scl, sda_q, n_sda;
	logic       accept, ack_miss, bc_full, busy, done;
	i2cee_pkg::launch_t lnch;

	// Latch a request when idle and work out the follow-on step
	always_comb begin
		accept = (phase_q == i2cee_pkg::PH_IDLE) && start_req;
		cur = accept ? i2cee_pkg::PH_ST1 : phase_q;
		n_read = accept ? action : read_q;
		n_addr = accept ? mem_address : addr_q;
		n_data = accept ? write_data : data_q;
		step_base = accept ? 3'd0 : step_q;
		step_inc = step_base + 3'd1;
		lnch = launch(n_read, step_inc, {cfg.device_select, 1'b0}, n_addr, n_data);
		ack_miss = sda_in && (ack_cnt_q >= cfg.ack_timeout);
		bc_inc = bit_count_q + 4'd1;
		bc_full = bc_inc >= 4'd8;
	end

	// Next state
	always_comb begin
		n_phase = cur;
		n_step = step_base;
		n_bit_count = bit_count_q;
		n_shift = shift_q;
		n_ack_cnt = ack_cnt_q;
		unique case (cur)
			i2cee_pkg::PH_ST1: n_phase = i2cee_pkg::PH_ST2;
			i2cee_pkg::PH_ST2: n_phase = i2cee_pkg::PH_ST3;
			i2cee_pkg::PH_ST3: n_phase = i2cee_pkg::PH_ST4;
			i2cee_pkg::PH_BSET: begin
				n_shift = {shift_q[6:0], 1'b0};
				n_phase = i2cee_pkg::PH_BHIGH;
			end
			i2cee_pkg::PH_BHIGH: n_phase = i2cee_pkg::PH_BLOW;
			i2cee_pkg::PH_BLOW: begin
				n_bit_count = bc_inc;
				n_phase = bc_full ? i2cee_pkg::PH_AREL : i2cee_pkg::PH_BSET;
			end
			i2cee_pkg::PH_AREL: begin
				n_ack_cnt = 8'd0;
				n_phase = i2cee_pkg::PH_APOLL;
			end
			i2cee_pkg::PH_APOLL: begin
				if (!sda_in || ack_miss) begin
					n_phase = i2cee_pkg::PH_AEND;
				end else begin
					n_ack_cnt = ack_cnt_q + 8'd1;
				end
			end
			i2cee_pkg::PH_RREL: begin
				n_shift = 8'd0;
				n_bit_count = 4'd0;
				n_phase = i2cee_pkg::PH_RHIGH1;
			end
			i2cee_pkg::PH_RHIGH1: n_phase = i2cee_pkg::PH_RHIGH2;
			i2cee_pkg::PH_RHIGH2: begin
				n_shift = {shift_q[6:0], sda_in};
				n_phase = i2cee_pkg::PH_RLOW;
			end
			i2cee_pkg::PH_SP1: n_phase = i2cee_pkg::PH_SP2;
			i2cee_pkg::PH_SP2: n_phase = i2cee_pkg::PH_SP3;
			i2cee_pkg::PH_SP3: n_phase = i2cee_pkg::PH_IDLE;
			default: n_phase = i2cee_pkg::PH_IDLE;
		endcase
		// Advance to the next transaction step at the end of a start, ack or read byte
		if (cur == i2cee_pkg::PH_ST4 || cur == i2cee_pkg::PH_AEND ||
				(cur == i2cee_pkg::PH_RLOW && bc_full)) begin
			n_step = step_inc;
			n_phase = lnch.phase;
			if (lnch.load) begin
				n_shift = lnch.byte_v;
				n_bit_count = 4'd0;
			end
		end else if (cur == i2cee_pkg::PH_RLOW) begin
			n_bit_count = bc_inc;
			n_phase = i2cee_pkg::PH_RHIGH1;
		end
	end

	// Outputs: line levels and status
	always_comb begin
		n_scl = scl_q;
		n_sda = sda_q;
		n_err = accept ? 1'b0 : err_q;
		n_rx = rx_q;
		busy = (cur != i2cee_pkg::PH_IDLE);
		done = 1'b0;
		unique case (cur)
			i2cee_pkg::PH_ST1:    n_sda = 1'b1;
			i2cee_pkg::PH_ST2:    n_scl = 1'b1;
			i2cee_pkg::PH_ST3:    n_sda = 1'b0;
			i2cee_pkg::PH_ST4:    n_scl = 1'b0;
			i2cee_pkg::PH_BSET:   n_sda = shift_q[7];
			i2cee_pkg::PH_BHIGH:  n_scl = 1'b1;
			i2cee_pkg::PH_BLOW:   n_scl = 1'b0;
			i2cee_pkg::PH_AREL:   n_sda = 1'b1;
			i2cee_pkg::PH_APOLL: begin
				n_scl = 1'b1;
				if (ack_miss) begin
					n_err = 1'b1;
				end
			end
			i2cee_pkg::PH_AEND:   n_scl = 1'b0;
			i2cee_pkg::PH_RREL:   n_sda = 1'b1;
			i2cee_pkg::PH_RHIGH1: n_scl = 1'b1;
			i2cee_pkg::PH_RHIGH2: n_scl = scl_q;
			i2cee_pkg::PH_RLOW: begin
				n_scl = 1'b0;
				if (bc_full) begin
					n_rx = shift_q;
				end
			end
			i2cee_pkg::PH_SP1:    n_sda = 1'b0;
			i2cee_pkg::PH_SP2:    n_scl = 1'b1;
			i2cee_pkg::PH_SP3: begin
				n_sda = 1'b1;
				done = 1'b1;
			end
			default:              busy = 1'b0;
		endcase
	end

	// Hold the state between accepted ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cee_pkg::PH_IDLE;
			bit_count_q <= 4'd0;
			shift_q <= 8'd0;
			ack_cnt_q <= 8'd0;
			step_q <= 3'd0;
			read_q <= 1'b0;
			addr_q <= 8'd0;
			data_q <= 8'd0;
			rx_q <= 8'd0;
			err_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
		end else if (step_en) begin
			phase_q <= n_phase;
			bit_count_q <= n_bit_count;
			shift_q <= n_shift;
			ack_cnt_q <= n_ack_cnt;
			step_q <= n_step;
			read_q <= n_read;
			addr_q <= n_addr;
			data_q <= n_data;
			rx_q <= n_rx;
			err_q <= n_err;
			scl_q <= n_scl;
			sda_q <= n_sda;
		end
	end

	assign res.scl = n_scl;
	assign res.sda_out = n_sda;
	assign res.busy_res = busy;
	assign res.done_res = done;
	assign res.read_data = n_rx;
	assign res.ack_failed = n_err;

	`ASSERT_CLK(a_bit_count_range, bit_count_q <= 4'd8, "bit counter passed eight")
	`ASSERT_CLK(a_done_to_idle, step_en && done |=> phase_q == i2cee_pkg::PH_IDLE, "no idle after stop")

endmodule
`default_nettype wire

/* design/i2c_eeprom_byte_access_master.sv */
// Top level of the I2C EEPROM byte access master: config registers and result buffer.
//
// Usage: every beat on the input channel is one bus timing tick (the bit delay).
// A tick with start_req set while idle starts a byte write (action 0) or a random
// byte read (action 1) at mem_address; requests during a transaction are dropped.
// Each input beat yields exactly one result beat carrying the SCL and SDA levels
// to drive for that tick, busy, done on the tick the stop completes, the last byte
// read and the sticky acknowledge failure flag of the transaction.
// The result of a tick is registered into the output buffer before it is offered.
// Throughput: one tick per cycle while in_ready is high; the sequencer state is updated in a single pass.
// A two-entry output buffer (output register plus skid) lets one more tick be
// taken while a result waits; in_ready drops only when both entries are full.
// Configuration: index 0 device_select, index 1 ack_timeout; writes always taken.
// Reset: bus lines released high, sequencer idle, buffer empty, device_select 80,
// ack_timeout 200.
`default_nettype none
`include "assert_macros.svh"
module i2c_eeprom_byte_access_master (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       start_req,
	input  wire logic       action,
	input  wire logic [7:0] mem_address,
	input  wire logic [7:0] write_data,
	input  wire logic       sda_in,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            scl,
	output logic            sda_out,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      read_data,
	output logic            ack_failed,
	// configuration channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [i2cee_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	i2cee_pkg::cfg_t cfg_q;
	i2cee_pkg::res_t res, head_q, skid_q;
	logic head_valid_q, skid_valid_q;
	logic push, pop;

	// Configuration registers, masked to width
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_select <= i2cee_pkg::DEVICE_SELECT_RST;
			cfg_q.ack_timeout <= i2cee_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				i2cee_pkg::REG_DEVICE_SELECT: cfg_q.device_select <= cfg_data[6:0];
				i2cee_pkg::REG_ACK_TIMEOUT:   cfg_q.ack_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !skid_valid_q;
	assign push = in_valid && in_ready;
	assign pop = head_valid_q && out_ready;

	i2cee_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (push),
		.start_req  (start_req),
		.action     (action),
		.mem_address(mem_address),
		.write_data (write_data),
		.sda_in     (sda_in),
		.cfg        (cfg_q),
		.res        (res)
	);

	// Buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!head_valid_q || pop) begin
			head_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Buffer payload
	always_ff @(posedge clk) begin
		if (!head_valid_q || pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				head_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = head_valid_q;
	assign scl = head_q.scl;
	assign sda_out = head_q.sda_out;
	assign busy_res = head_q.busy_res;
	assign done_res = head_q.done_res;
	assign read_data = head_q.read_data;
	assign ack_failed = head_q.ack_failed;

	`ASSERT_CLK(a_skid_needs_head, skid_valid_q |-> head_valid_q, "skid filled with empty head")
	`ASSERT_NEVER(a_done_not_busy, head_valid_q && head_q.done_res && !head_q.busy_res, "done without busy")
	`ASSERT_CLK(a_full_blocks_input, skid_valid_q && !out_ready |=> skid_valid_q, "skid beat lost")

endmodule
`default_nettype wire
